// ===== hw/rtl/alps_pkg.sv =====
// Package: shared constants, codes and types of the LED serializer.
`timescale 1ns / 1ps
`default_nettype none
package alps_pkg;

    localparam int NUM_LEDS     = 8;
    localparam int LED_W        = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int BITS_PER_LED = 24;
    localparam int BIT_W        = $clog2(BITS_PER_LED);
    localparam int COLOR_W      = 24;
    localparam int TICK_W       = 7;
    localparam int SLOTS_W      = 8;
    localparam int APB_AW       = 4;
    localparam int APB_DW       = 32;

    localparam logic [TICK_W-1:0]  PERIOD_RST  = TICK_W'(20);
    localparam logic [TICK_W-1:0]  HIGH1_RST   = TICK_W'(13);
    localparam logic [TICK_W-1:0]  HIGH0_RST   = TICK_W'(6);
    localparam logic [SLOTS_W-1:0] TRAIL_RST   = SLOTS_W'(50);
    localparam logic [BIT_W-1:0]   BIT_MSB     = BIT_W'(BITS_PER_LED - 1);
    localparam logic [LED_W-1:0]   LED_LAST    = LED_W'(NUM_LEDS - 1);

    typedef enum logic [1:0] {
        CMD_WRITE       = 2'd0,
        CMD_START       = 2'd1,
        CMD_TICK        = 2'd2,
        CMD_CLEAR_START = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_PERIOD = 2'd0,
        REG_HIGH1  = 2'd1,
        REG_HIGH0  = 2'd2,
        REG_TRAIL  = 2'd3
    } t_reg_idx;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic               we;
        logic               clr;
        logic [LED_W-1:0]   addr;
        logic [COLOR_W-1:0] data;
    } t_store_wr;

endpackage
`default_nettype wire

// ===== hw/rtl/alps_color_store.sv =====
// Color store: one-port-read synchronous memory with per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
module alps_color_store
    import alps_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_store_wr          i_wr,
    input  wire logic               i_rd_en,
    input  wire logic [LED_W-1:0]   i_rd_addr,
    output logic      [COLOR_W-1:0] o_rd_data
);

    logic [COLOR_W-1:0] r_mem [NUM_LEDS];
    logic [NUM_LEDS-1:0] r_vld;
    logic [COLOR_W-1:0] r_rd_data;
    logic               r_rd_vld;

    // Entries never written since reset or the last clear read as black.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.clr) begin
            r_vld <= '0;
        end else if (i_wr.we) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/addressable_led_pwm_serializer.sv =====
// Top level: addressable LED serializer with color memory and APB registers.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready  | command, led_index, red, green, blue
//  out     | output    | o_out_valid / i_out_ready| line_level, busy_res, frame_done
//  cfg     | input     | psel/penable/pwrite      | paddr, pwdata -> prdata, pready
//
// Each word is accepted in the idle state, which launches the color memory
// read, and is then executed on the read data in the execute state, which
// loads the output register. The color memory read is registered.
// The result waits in the output register; a stalled output holds the
// execute step (and so the input) until the register is taken.
// Reset (i_rst_n low, synchronous) clears control state, the memory valid
// bits (the store reads black, no clearing pass) and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none
module addressable_led_pwm_serializer
    import alps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input words
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_command,
    input  wire logic [2:0]        i_led_index,
    input  wire logic [7:0]        i_red,
    input  wire logic [7:0]        i_green,
    input  wire logic [7:0]        i_blue,
    // result words
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_line_level,
    output logic                   o_busy_res,
    output logic                   o_frame_done,
    // register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TICK_W-1:0]  r_period;
    logic [TICK_W-1:0]  r_high1;
    logic [TICK_W-1:0]  r_high0;
    logic [SLOTS_W-1:0] r_trail;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_high1  <= HIGH1_RST;
            r_high0  <= HIGH0_RST;
            r_trail  <= TRAIL_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PERIOD: r_period <= pwdata[TICK_W-1:0];
                REG_HIGH1:  r_high1  <= pwdata[TICK_W-1:0];
                REG_HIGH0:  r_high0  <= pwdata[TICK_W-1:0];
                REG_TRAIL:  r_trail  <= pwdata[SLOTS_W-1:0];
                default:    r_trail  <= r_trail;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_PERIOD: prdata = APB_DW'(r_period);
            REG_HIGH1:  prdata = APB_DW'(r_high1);
            REG_HIGH0:  prdata = APB_DW'(r_high0);
            REG_TRAIL:  prdata = APB_DW'(r_trail);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;
    logic   in_fire;
    logic   exec_fire;
    logic   rd_en;

    assign in_fire = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_fire)   n_state = ST_EXEC;
            ST_EXEC: if (exec_fire) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Execute only when the output register is empty or being drained.
    always_comb begin
        o_in_ready = 1'b0;
        exec_fire  = 1'b0;
        rd_en      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                rd_en      = i_in_valid;
            end
            ST_EXEC: begin
                exec_fire = !o_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Hold the accepted word for the execute step.
    t_cmd               r_cmd;
    logic [2:0]         r_led_index;
    logic [COLOR_W-1:0] r_color;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd       <= t_cmd'(i_command);
            r_led_index <= i_led_index;
            r_color     <= {i_green, i_red, i_blue};
        end
    end

    // ------------------------------------------------------------------
    // Frame state: LED, bit within LED, trailer slots, tick within slot
    // ------------------------------------------------------------------
    logic               r_sending,  n_sending;
    logic               r_in_data,  n_in_data;
    logic [LED_W-1:0]   r_led,      n_led;
    logic [BIT_W-1:0]   r_bitpos,   n_bitpos;
    logic [SLOTS_W-1:0] r_trail_cnt, n_trail_cnt;
    logic [TICK_W-1:0]  r_tick,     n_tick;

    logic [COLOR_W-1:0] rd_data;
    t_store_wr          st_wr;

    logic               res_line;
    logic               res_busy;
    logic               res_done;

    logic               cur_bit;
    logic [TICK_W-1:0]  high_ticks;
    logic [TICK_W-1:0]  period_eff;
    logic [TICK_W:0]    tick_inc;
    logic [SLOTS_W:0]   trail_inc;

    assign cur_bit    = rd_data[r_bitpos];
    assign high_ticks = cur_bit ? r_high1 : r_high0;
    // A zero period behaves as a one-tick slot.
    assign period_eff = (r_period == '0) ? TICK_W'(1) : r_period;
    assign tick_inc   = {1'b0, r_tick} + (TICK_W+1)'(1);
    assign trail_inc  = {1'b0, r_trail_cnt} + (SLOTS_W+1)'(1);

    always_comb begin
        n_sending   = r_sending;
        n_in_data   = r_in_data;
        n_led       = r_led;
        n_bitpos    = r_bitpos;
        n_trail_cnt = r_trail_cnt;
        n_tick      = r_tick;
        res_line    = 1'b0;
        res_done    = 1'b0;
        st_wr       = '0;

        case (r_cmd)
            CMD_TICK: begin
                if (r_sending) begin
                    res_line = r_in_data && (r_tick < high_ticks);
                    if (tick_inc >= {1'b0, period_eff}) begin
                        // Slot complete: advance to the next slot.
                        n_tick = '0;
                        if (r_in_data) begin
                            if (r_bitpos == '0) begin
                                n_bitpos = BIT_MSB;
                                if (r_led == LED_LAST) begin
                                    n_in_data   = 1'b0;
                                    n_trail_cnt = '0;
                                    res_done    = (r_trail == '0);
                                end else begin
                                    n_led = r_led + LED_W'(1);
                                end
                            end else begin
                                n_bitpos = r_bitpos - BIT_W'(1);
                            end
                        end else begin
                            if (trail_inc >= {1'b0, r_trail}) begin
                                res_done = 1'b1;
                            end else begin
                                n_trail_cnt = trail_inc[SLOTS_W-1:0];
                            end
                        end
                    end else begin
                        n_tick = tick_inc[TICK_W-1:0];
                    end
                    // Frame over: drop busy and rewind to the first slot.
                    if (res_done) begin
                        n_sending   = 1'b0;
                        n_in_data   = 1'b1;
                        n_led       = '0;
                        n_bitpos    = BIT_MSB;
                        n_trail_cnt = '0;
                        n_tick      = '0;
                    end
                end
            end
            CMD_WRITE: begin
                if (!r_sending && (int'(r_led_index) < NUM_LEDS)) begin
                    st_wr.we   = exec_fire;
                    st_wr.addr = LED_W'(r_led_index);
                    st_wr.data = r_color;
                end
            end
            CMD_START: begin
                if (!r_sending) begin
                    n_sending = 1'b1;
                end
            end
            CMD_CLEAR_START: begin
                if (!r_sending) begin
                    st_wr.clr = exec_fire;
                    n_sending = 1'b1;
                end
            end
            default: begin
                n_sending = r_sending;
            end
        endcase
    end

    // A tick reports busy when a frame was running; other words report the
    // state after the command.
    assign res_busy = (r_cmd == CMD_TICK) ? r_sending : n_sending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending   <= 1'b0;
            r_in_data   <= 1'b1;
            r_led       <= '0;
            r_bitpos    <= BIT_MSB;
            r_trail_cnt <= '0;
            r_tick      <= '0;
        end else if (exec_fire) begin
            r_sending   <= n_sending;
            r_in_data   <= n_in_data;
            r_led       <= n_led;
            r_bitpos    <= n_bitpos;
            r_trail_cnt <= n_trail_cnt;
            r_tick      <= n_tick;
        end
    end

    // Color memory: read the current LED when a word is accepted.
    alps_color_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (st_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_led),
        .o_rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic r_line;
    logic r_busy;
    logic r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_line <= res_line;
            r_busy <= res_busy;
            r_done <= res_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_level = r_line;
    assign o_busy_res   = r_busy;
    assign o_frame_done = r_done;

endmodule
`default_nettype wire

// ===== hw/rtl/alps_checker.sv =====
// Checker: port-level properties of the LED serializer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module alps_checker
    import alps_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic              o_line_level,
    input wire logic              o_busy_res,
    input wire logic              o_frame_done,
    input wire logic              pready
);

    // A frame can only end on a word sent while busy.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> o_busy_res)
        else $error("frame_done without busy_res");

    // The line is only driven high during a frame.
    a_line_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_line_level) |-> o_busy_res)
        else $error("line_level high while idle");

    // One word at a time: no accept in the cycle after an accept.
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted on consecutive cycles");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_line_level) && $stable(o_busy_res)
             && $stable(o_frame_done)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind addressable_led_pwm_serializer alps_checker u_alps_checker (.*);
`default_nettype wire
